/* hw/rtl/dipp_pkg.sv */
// Shared constants, character codes and queue entry type for the packet parser.
package dipp_pkg;

    // Number of values one packet can store.
    localparam int VALUE_SLOTS = 8;
    localparam int CNT_W       = $clog2(VALUE_SLOTS + 1);
    localparam int IDX_W       = (VALUE_SLOTS > 1) ? $clog2(VALUE_SLOTS) : 1;

    localparam logic [3:0] MAX_CHARS = 4'd15;

    // Depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic       CMD_RECEIVE = 1'b0;
    localparam logic       CMD_READ    = 1'b1;

    localparam logic [7:0] CH_START = 8'h73;  // 's'
    localparam logic [7:0] CH_END   = 8'h65;  // 'e'
    localparam logic [7:0] CH_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CH_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] CH_NINE  = 8'h39;  // '9'

    typedef enum logic [2:0] {
        KIND_READ,
        KIND_START,
        KIND_END,
        KIND_COMMA,
        KIND_MINUS,
        KIND_DIGIT,
        KIND_OTHER
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [3:0]  digit;
        logic [6:0]  index;
    } op_t;

endpackage

/* hw/rtl/dipp_front.sv */
// Front end: accepts input beats and classifies each into a queue entry.
module dipp_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [7:0]           rx_byte,
    input  logic [6:0]           read_index,
    input  logic                 queue_full,
    output logic                 push,
    output dipp_pkg::op_t        push_op
);

    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    always_comb
    begin
        push_op.index = read_index;
        push_op.digit = 4'(rx_byte - dipp_pkg::CH_ZERO);
        if (command == dipp_pkg::CMD_READ)
        begin
            push_op.kind = dipp_pkg::KIND_READ;
        end
        else if (rx_byte == dipp_pkg::CH_START)
        begin
            push_op.kind = dipp_pkg::KIND_START;
        end
        else if (rx_byte == dipp_pkg::CH_END)
        begin
            push_op.kind = dipp_pkg::KIND_END;
        end
        else if (rx_byte == dipp_pkg::CH_COMMA)
        begin
            push_op.kind = dipp_pkg::KIND_COMMA;
        end
        else if (rx_byte == dipp_pkg::CH_MINUS)
        begin
            push_op.kind = dipp_pkg::KIND_MINUS;
        end
        else if (rx_byte inside {[dipp_pkg::CH_ZERO:dipp_pkg::CH_NINE]})
        begin
            push_op.kind = dipp_pkg::KIND_DIGIT;
        end
        else
        begin
            push_op.kind = dipp_pkg::KIND_OTHER;
        end
    end

endmodule

/* hw/rtl/dipp_queue.sv */
// Short FIFO of classified beats between the front and back ends.
module dipp_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  dipp_pkg::op_t    push_op,
    input  logic             pop,
    output logic             full,
    output logic             not_empty,
    output dipp_pkg::op_t    head_op
);

    dipp_pkg::op_t                   slot_reg [dipp_pkg::QUEUE_DEPTH];
    logic [dipp_pkg::QPTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [dipp_pkg::QPTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [dipp_pkg::QCNT_W-1:0]     count_reg,  count_next;

    localparam logic [dipp_pkg::QPTR_W-1:0] LAST_PTR =
        dipp_pkg::QPTR_W'(dipp_pkg::QUEUE_DEPTH - 1);
    localparam logic [dipp_pkg::QCNT_W-1:0] FULL_COUNT =
        dipp_pkg::QCNT_W'(dipp_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign head_op   = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload slots carry no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* hw/rtl/dipp_back.sv */
// Back end: parser state, value store and registered result beat.
module dipp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 op_valid,
    input  dipp_pkg::op_t        op,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           parse_phase,
    output logic [3:0]           value_count,
    output logic signed [15:0]   read_value,
    output logic                 packet_done
);

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_RECV = 2'd1,
        PH_DONE = 2'd2
    } phase_t;

    localparam logic [dipp_pkg::CNT_W-1:0] LEN_LIMIT =
        dipp_pkg::CNT_W'(dipp_pkg::VALUE_SLOTS);

    phase_t                       phase_reg, phase_next;
    logic [dipp_pkg::CNT_W-1:0]   field_index_reg, field_index_next;
    logic [dipp_pkg::CNT_W-1:0]   valid_count_reg, valid_count_next;
    logic [3:0]                   char_len_reg, char_len_next;
    logic                         neg_reg, neg_next;
    logic [15:0]                  acc_reg, acc_next;

    logic                         o_valid_reg;
    logic [1:0]                   o_phase_reg;
    logic [3:0]                   o_count_reg;
    logic                         o_rd_valid_reg, rd_valid_next;
    logic                         o_done_reg, done_next;

    logic [15:0]                  value_mem [dipp_pkg::VALUE_SLOTS];
    logic [15:0]                  rdata_reg;
    logic                         wr_en;
    logic [15:0]                  field_value;
    logic                         has_room;

    // Advance when the result slot is free or being drained.
    assign pop = op_valid && (!o_valid_reg || out_ready);

    assign field_value = neg_reg ? 16'(16'd0 - acc_reg) : acc_reg;
    assign has_room    = (field_index_reg < LEN_LIMIT);

    always_comb
    begin
        phase_next       = phase_reg;
        field_index_next = field_index_reg;
        valid_count_next = valid_count_reg;
        char_len_next    = char_len_reg;
        neg_next         = neg_reg;
        acc_next         = acc_reg;
        rd_valid_next    = 1'b0;
        done_next        = 1'b0;
        wr_en            = 1'b0;

        if (op.kind == dipp_pkg::KIND_READ)
        begin
            rd_valid_next = ({1'b0, op.index} < 8'(valid_count_reg));
        end
        else if (phase_reg != PH_RECV)
        begin
            if (op.kind == dipp_pkg::KIND_START)
            begin
                phase_next       = PH_RECV;
                field_index_next = '0;
                char_len_next    = '0;
                neg_next         = 1'b0;
                acc_next         = '0;
                if (phase_reg == PH_DONE)
                begin
                    valid_count_next = '0;
                end
            end
        end
        else
        begin
            case (op.kind)
                dipp_pkg::KIND_END:
                begin
                    if (char_len_reg != '0 && has_room)
                    begin
                        wr_en            = 1'b1;
                        valid_count_next = field_index_reg + 1'b1;
                    end
                    phase_next = PH_DONE;
                    done_next  = 1'b1;
                end
                dipp_pkg::KIND_COMMA:
                begin
                    if (char_len_reg != '0)
                    begin
                        if (has_room)
                        begin
                            wr_en            = 1'b1;
                            field_index_next = field_index_reg + 1'b1;
                        end
                        char_len_next = '0;
                        neg_next      = 1'b0;
                        acc_next      = '0;
                    end
                end
                dipp_pkg::KIND_MINUS:
                begin
                    if (char_len_reg >= dipp_pkg::MAX_CHARS || char_len_reg != '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        neg_next      = 1'b1;
                        char_len_next = char_len_reg + 1'b1;
                    end
                end
                dipp_pkg::KIND_DIGIT:
                begin
                    if (char_len_reg >= dipp_pkg::MAX_CHARS)
                    begin
                        phase_next = PH_IDLE;
                    end
                    else
                    begin
                        // acc * 10 + digit, wrapping at 16 bits
                        acc_next      = 16'({acc_reg, 3'b000} + {acc_reg, 1'b0}
                                            + {12'd0, op.digit});
                        char_len_next = char_len_reg + 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            field_index_reg <= '0;
            valid_count_reg <= '0;
            char_len_reg    <= '0;
            neg_reg         <= 1'b0;
            acc_reg         <= '0;
            o_valid_reg     <= 1'b0;
            o_phase_reg     <= '0;
            o_count_reg     <= '0;
            o_rd_valid_reg  <= 1'b0;
            o_done_reg      <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                phase_reg       <= phase_next;
                field_index_reg <= field_index_next;
                valid_count_reg <= valid_count_next;
                char_len_reg    <= char_len_next;
                neg_reg         <= neg_next;
                acc_reg         <= acc_next;
                o_phase_reg     <= 2'(phase_next);
                o_count_reg     <= 4'(valid_count_next);
                o_rd_valid_reg  <= rd_valid_next;
                o_done_reg      <= done_next;
                o_valid_reg     <= 1'b1;
            end
            else if (out_ready)
            begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    // Value store: written on field close, read data held with the result beat.
    always_ff @(posedge clk)
    begin
        if (pop && wr_en)
        begin
            value_mem[field_index_reg[dipp_pkg::IDX_W-1:0]] <= field_value;
        end
        if (pop && op.kind == dipp_pkg::KIND_READ)
        begin
            rdata_reg <= value_mem[op.index[dipp_pkg::IDX_W-1:0]];
        end
    end

    assign out_valid   = o_valid_reg;
    assign parse_phase = o_phase_reg;
    assign value_count = o_count_reg;
    assign read_value  = o_rd_valid_reg ? signed'(rdata_reg) : 16'sd0;
    assign packet_done = o_done_reg;

endmodule

/* hw/rtl/delimited_int_packet_parser.sv */
// Top level of the delimited signed-integer packet parser.
//
// Each input beat is either a received character (command 0) or a read of a
// stored value (command 1); every beat yields exactly one result beat carrying
// the parse phase, the count of valid stored values, the read value (0 for
// receives or out-of-range reads) and a packet-done flag. Packets look like
// 's' v0 ',' v1 ... 'e'; values are int16 with wraparound, up to VALUE_SLOTS of
// them are kept. The block sustains one beat per clock while out_ready is held
// high: the parser state update (multiply-by-ten and add) and the value store
// access both complete within the back end for each popped beat, and the
// two-entry queue plus the result register let input and output stall
// independently. An accepted beat passes through the queue, then the result register.
// The value store needs no clearing pass after reset.
module delimited_int_packet_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 command,
    input  logic [7:0]           rx_byte,
    input  logic [6:0]           read_index,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           parse_phase,
    output logic [3:0]           value_count,
    output logic signed [15:0]   read_value,
    output logic                 packet_done
);

    logic            push;
    dipp_pkg::op_t   push_op;
    logic            queue_full;
    logic            queue_not_empty;
    dipp_pkg::op_t   head_op;
    logic            pop;

    // Classify incoming beats; hold off when the queue is full.
    dipp_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .command    (command),
        .rx_byte    (rx_byte),
        .read_index (read_index),
        .queue_full (queue_full),
        .push       (push),
        .push_op    (push_op)
    );

    dipp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_op   (push_op),
        .pop       (pop),
        .full      (queue_full),
        .not_empty (queue_not_empty),
        .head_op   (head_op)
    );

    // Execute queued beats in order and present one result beat each.
    dipp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .op_valid    (queue_not_empty),
        .op          (head_op),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .parse_phase (parse_phase),
        .value_count (value_count),
        .read_value  (read_value),
        .packet_done (packet_done)
    );

`ifndef NO_ASSERTIONS
    // A full queue only builds up behind a stalled result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("queue full without a pending result beat");

    // A packet end always leaves the parser in the complete phase.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && packet_done |-> parse_phase == 2'd2)
        else $error("packet_done outside complete phase");

    // Read data and packet completion never share a beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && read_value != 16'sd0 |-> !packet_done)
        else $error("read value on a receive beat");

    // The stored count never exceeds the store depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> 32'(value_count) <= dipp_pkg::VALUE_SLOTS)
        else $error("value_count beyond store depth");
`endif

endmodule

/* test/delimited_int_packet_parser_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the delimited signed-integer packet parser.
module delimited_int_packet_parser_tb;

    // Useful beats (reads, and bytes the parser does not simply ignore) in the random part.
    localparam int ITEM_TARGET  = 1150;
    // Cycles with no beat on either channel before the run is declared hung.
    localparam int STALL_LIMIT  = 2000;
    localparam int REPORT_LIMIT = 10;
    // Extra cycles after the last expected result, to catch stray result beats.
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_RECEIVING = 2'd1,
        PH_COMPLETE  = 2'd2
    } phase_t;

    typedef struct {
        logic [1:0]         phase;
        logic [3:0]         count;
        logic signed [15:0] value;
        logic               done;
    } parse_result_t;

    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic               command    = dipp_pkg::CMD_RECEIVE;
    logic [7:0]         rx_byte    = 8'h00;
    logic [6:0]         read_index = 7'd0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [1:0]         parse_phase;
    logic [3:0]         value_count;
    logic signed [15:0] read_value;
    logic               packet_done;

    always #5 clk = ~clk;

    delimited_int_packet_parser uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .rx_byte     (rx_byte),
        .read_index  (read_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .parse_phase (parse_phase),
        .value_count (value_count),
        .read_value  (read_value),
        .packet_done (packet_done)
    );

    // ------------------------------------------------------------------
    // Parser mirror: state of the block as the testbench believes it.
    // ------------------------------------------------------------------
    phase_t      pm_phase = PH_IDLE;
    logic [3:0]  pm_field = '0;     // slot the current field goes into
    logic [3:0]  pm_count = '0;     // number of valid stored values
    logic [3:0]  pm_chars = '0;     // characters taken in the current field
    logic        pm_neg   = 1'b0;
    logic [15:0] pm_acc   = '0;     // magnitude, wraps modulo 2^16
    logic [15:0] pm_store [dipp_pkg::VALUE_SLOTS];

    // Expected result beats, oldest first.
    parse_result_t pending_parse_results [$];

    int fail_count   = 0;
    int result_beats = 0;
    int useful_beats = 0;
    int burst_left   = 0;
    int quiet_cycles = 0;

    function automatic void open_packet();
        pm_phase = PH_RECEIVING;
        pm_field = '0;
        pm_chars = '0;
        pm_neg   = 1'b0;
        pm_acc   = '0;
    endfunction

    // Advance the mirror by one accepted beat and return the result it should produce.
    function automatic parse_result_t predict_parser_result(input logic cmd,
                                                            input logic [7:0] ch,
                                                            input logic [6:0] idx);
        parse_result_t r;
        logic [15:0]   field_val;
        r.value   = '0;
        r.done    = 1'b0;
        field_val = pm_neg ? (16'd0 - pm_acc) : pm_acc;
        if (cmd == dipp_pkg::CMD_RECEIVE) begin
            case (pm_phase)
                PH_IDLE:
                begin
                    if (ch == dipp_pkg::CH_START)
                        open_packet();
                end
                PH_COMPLETE:
                begin
                    // A new packet from the complete phase also drops the old count.
                    if (ch == dipp_pkg::CH_START)
                    begin
                        open_packet();
                        pm_count = '0;
                    end
                end
                default:
                begin
                    if (ch == dipp_pkg::CH_END)
                    begin
                        // An empty last field leaves the count as it was.
                        if (pm_chars != 0 && pm_field < dipp_pkg::VALUE_SLOTS)
                        begin
                            pm_store[pm_field] = field_val;
                            pm_count = pm_field + 4'd1;
                        end
                        pm_phase = PH_COMPLETE;
                        r.done   = 1'b1;
                    end
                    else if (ch == dipp_pkg::CH_COMMA)
                    begin
                        // Empty fields are skipped; a full store holds its slot.
                        if (pm_chars != 0)
                        begin
                            if (pm_field < dipp_pkg::VALUE_SLOTS)
                            begin
                                pm_store[pm_field] = field_val;
                                pm_field = pm_field + 4'd1;
                            end
                            pm_chars = '0;
                            pm_neg   = 1'b0;
                            pm_acc   = '0;
                        end
                    end
                    else if ((ch >= dipp_pkg::CH_ZERO && ch <= dipp_pkg::CH_NINE) ||
                             ch == dipp_pkg::CH_MINUS)
                    begin
                        if (pm_chars >= dipp_pkg::MAX_CHARS)
                            pm_phase = PH_IDLE;         // sixteenth character
                        else if (ch == dipp_pkg::CH_MINUS)
                        begin
                            if (pm_chars != 0)
                                pm_phase = PH_IDLE;     // minus not in front
                            else
                            begin
                                pm_neg   = 1'b1;
                                pm_chars = pm_chars + 4'd1;
                            end
                        end
                        else
                        begin
                            pm_acc   = pm_acc * 16'd10 + {8'd0, ch - dipp_pkg::CH_ZERO};
                            pm_chars = pm_chars + 4'd1;
                        end
                    end
                    else
                        pm_phase = PH_IDLE;             // any other byte, 's' too
                end
            endcase
        end
        else if (idx < pm_count && idx < dipp_pkg::VALUE_SLOTS)
            r.value = pm_store[idx];
        r.phase = pm_phase;
        r.count = pm_count;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Sender: one beat per call, in bursts of random length with random
    // gaps. Valid stays high across a burst, so back-to-back beats never
    // drop it.
    // ------------------------------------------------------------------
    task automatic send_beat(input logic cmd, input logic [7:0] ch, input logic [6:0] idx);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        command    <= cmd;
        rx_byte    <= ch;
        read_index <= idx;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        // Beats that the parser merely ignores do not count toward the target.
        if (cmd == dipp_pkg::CMD_READ || pm_phase == PH_RECEIVING || ch == dipp_pkg::CH_START)
            useful_beats++;
        pending_parse_results.push_back(predict_parser_result(cmd, ch, idx));
    endtask

    // The unused field of each beat carries random bits.
    task automatic send_byte(input logic [7:0] ch);
        send_beat(dipp_pkg::CMD_RECEIVE, ch, 7'($urandom_range(0, 127)));
    endtask

    task automatic send_read(input logic [6:0] idx);
        send_beat(dipp_pkg::CMD_READ, 8'($urandom_range(0, 255)), idx);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Mostly indexes near the store, sometimes anywhere in the 7-bit range.
    function automatic logic [6:0] pick_index();
        if ($urandom_range(0, 5) == 0)
            return 7'($urandom_range(0, 127));
        return 7'($urandom_range(0, dipp_pkg::VALUE_SLOTS + 1));
    endfunction

    // ------------------------------------------------------------------
    // Receiver: ready follows a rotating pattern, reloaded every so often.
    // Bit 0 is always set so a stall never lasts a full rotation.
    // ------------------------------------------------------------------
    logic [15:0] ready_pattern = 16'hFFFF;
    int          pattern_age   = 0;

    always @(negedge clk)
    begin
        if (pattern_age == 0)
        begin
            pattern_age = $urandom_range(50, 300);
            case ($urandom_range(0, 3))
                0: ready_pattern = 16'hFFFF;                         // no stalls
                1: ready_pattern = 16'($urandom & $urandom) | 16'h0001;  // heavy stalls
                default: ready_pattern = 16'($urandom) | 16'h0001;
            endcase
        end
        pattern_age--;
        out_ready     <= ready_pattern[0];
        ready_pattern = {ready_pattern[0], ready_pattern[15:1]};
    end

    // ------------------------------------------------------------------
    // Result check: each result beat against the oldest expectation.
    // ------------------------------------------------------------------
    function automatic void note_failure(input string msg);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endfunction

    parse_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_parse_results.size() == 0)
                note_failure($sformatf("result beat %0d arrived with nothing expected",
                                       result_beats));
            else
            begin
                want = pending_parse_results.pop_front();
                if (parse_phase !== want.phase || value_count !== want.count ||
                    read_value !== want.value || packet_done !== want.done)
                    note_failure($sformatf({"result beat %0d: expected phase %0d count %0d ",
                        "value %0d done %0d, got phase %0d count %0d value %0d done %0d"},
                        result_beats, want.phase, want.count, want.value, want.done,
                        parse_phase, value_count, read_value, packet_done));
            end
            result_beats++;
        end
    end

    // Watchdog: end the run when no beat moves on either channel for too long.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Lone minus stores 0, the most negative int16, and a magnitude that wraps;
    // then a read inside the store and one at the top of the index range.
    task automatic test_signs_and_wrap();
        send_text("s-,-32768,70000e");
        send_read(7'd2);
        send_read(7'd127);
    endtask

    // Misplaced minus, a stray byte at both ends of the byte range, empty
    // fields, and a new packet from the complete phase clearing the count.
    task automatic test_malformed_input();
        send_text("s1-");       // from complete: count drops, then minus out of place
        send_byte(8'h00);       // ignored while idle
        send_byte(dipp_pkg::CH_START);
        send_byte(8'hFF);       // foreign byte ends the packet
        send_text("s,e");       // only empty fields, count stays
        send_read(7'd0);
    endtask

    // Mostly well-formed packets with random content; some are cut short,
    // corrupted, overlong or carry too many fields. Reads fall anywhere.
    task automatic send_random_packet();
        logic [7:0] pkt [$];
        int         nfields;
        int         nchar;
        int         pos;
        logic       neg;
        pkt.push_back(dipp_pkg::CH_START);
        nfields = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
        for (int i = 0; i < nfields; i++)
        begin
            if (i > 0)
                pkt.push_back(dipp_pkg::CH_COMMA);
            if ($urandom_range(0, 9) == 0)
                continue;                               // empty field
            neg = ($urandom_range(0, 2) == 0);
            if (neg)
                pkt.push_back(dipp_pkg::CH_MINUS);
            if ($urandom_range(0, 9) == 0)
                nchar = $urandom_range(13, 17) - neg;   // near or past the length limit
            else if (neg && $urandom_range(0, 7) == 0)
                nchar = 0;                              // lone minus
            else
                nchar = $urandom_range(1, 5);
            for (int k = 0; k < nchar; k++)
                pkt.push_back(dipp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 7) != 0)
            pkt.push_back(dipp_pkg::CH_END);
        if (pkt.size() > 1 && $urandom_range(0, 7) == 0)
        begin
            pos = $urandom_range(1, pkt.size() - 1);
            case ($urandom_range(0, 2))
                0: pkt[pos] = dipp_pkg::CH_MINUS;
                1: pkt[pos] = dipp_pkg::CH_START;
                default: pkt[pos] = 8'($urandom_range(0, 255));
            endcase
        end
        foreach (pkt[i])
        begin
            if ($urandom_range(0, 15) == 0)
                send_read(pick_index());
            send_byte(pkt[i]);
        end
        repeat ($urandom_range(0, 4)) send_read(pick_index());
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
    endtask

    task automatic test_random_traffic();
        int start_beats;
        start_beats = useful_beats;
        while (useful_beats - start_beats < ITEM_TARGET)
            send_random_packet();
    endtask

    initial
    begin
        foreach (pm_store[i])
            pm_store[i] = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_signs_and_wrap();
        test_malformed_input();
        test_random_traffic();

        // Drop valid, drain the outstanding results, then watch for strays.
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_parse_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
